@@ hdl/lrt_pkg.sv @@
// Shared types and constants for the LRU replacement tracker.
`default_nettype none

package lrt_pkg;

    localparam int FRAMES_DEF = 64;
    localparam int KIND_W     = 2;
    localparam int ID_W       = 6;
    localparam int CNT_W      = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_VICTIM = 2'd1,
        KIND_ERASE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } state_t;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_APPEND,
        MODE_MOVE,
        MODE_REMOVE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t      mode;
        logic [ID_W-1:0] key;
    } cell_ctl_t;

    typedef struct packed {
        logic ready;
        logic apply;
    } seq_ctl_t;

endpackage

`default_nettype wire

@@ hdl/lrt_in_if.sv @@
// Request channel: operation kind and frame number.
`default_nettype none

interface lrt_in_if;
    logic                      valid;
    logic                      ready;
    logic [lrt_pkg::KIND_W-1:0] kind;
    logic [lrt_pkg::ID_W-1:0]   frame_id;

    modport source (output valid, kind, frame_id, input ready);
    modport sink   (input valid, kind, frame_id, output ready);
endinterface

`default_nettype wire

@@ hdl/lrt_out_if.sv @@
// Response channel: hit flag, evicted frame and tracked count.
`default_nettype none

interface lrt_out_if;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [lrt_pkg::ID_W-1:0]  victim_id;
    logic [lrt_pkg::CNT_W-1:0] tracked_count;

    modport source (output valid, found, victim_id, tracked_count, input ready);
    modport sink   (input valid, found, victim_id, tracked_count, output ready);
endinterface

`default_nettype wire

@@ hdl/lru_replacement_tracker_core.sv @@
// The request word is taken in idle, compared in the compare state and answered in the apply
// state once the response register is free. Each operation compares the key in
// every cell of the row, then shifts the row once, and the next word waits for that shift.
// The response register lets the next request in while an earlier response is pending.
// Reset: asynchronous, clears every cell's valid flag and the count at once; no clearing pass.
`default_nettype none

module lru_replacement_tracker_core #(
    parameter int FRAMES = lrt_pkg::FRAMES_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    lrt_in_if.sink     req,
    lrt_out_if.source  rsp
);

    localparam int ID_W  = lrt_pkg::ID_W;
    localparam int CNT_W = lrt_pkg::CNT_W;

    lrt_pkg::seq_ctl_t          seq_ctl;
    lrt_pkg::cell_ctl_t         cell_ctl;

    logic [lrt_pkg::KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]            key_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;

    logic                       out_valid_reg;
    logic                       found_reg;
    logic                       found_next;
    logic [ID_W-1:0]            victim_reg;
    logic [ID_W-1:0]            victim_next;

    logic [FRAMES-1:0]          valid_vec;
    logic [FRAMES-1:0]          hit_vec;
    logic [FRAMES-1:0]          sel_vec;
    logic [ID_W-1:0]            id_vec [FRAMES];

    logic                       out_free;
    logic                       hit_any;
    logic                       id_ok;
    lrt_pkg::cell_mode_t        mode;

    assign out_free = !out_valid_reg || rsp.ready;
    assign hit_any  = |hit_vec;
    assign id_ok    = int'(key_reg) < FRAMES;

    lrt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .out_free (out_free),
        .ctl      (seq_ctl)
    );

    assign req.ready = seq_ctl.ready;

    always_comb
    begin
        mode        = lrt_pkg::MODE_HOLD;
        found_next  = 1'b0;
        victim_next = '0;
        cnt_next    = cnt_reg;
        sel_vec     = ~(hit_vec - FRAMES'(1));
        case (kind_reg)
            lrt_pkg::KIND_INSERT:
            begin
                if (id_ok)
                begin
                    found_next = hit_any;
                    if (hit_any)
                    begin
                        mode = lrt_pkg::MODE_MOVE;
                    end
                    else
                    begin
                        mode     = lrt_pkg::MODE_APPEND;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            lrt_pkg::KIND_VICTIM:
            begin
                sel_vec = '1;
                if (cnt_reg != '0)
                begin
                    mode        = lrt_pkg::MODE_REMOVE;
                    found_next  = 1'b1;
                    victim_next = id_vec[0];
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
            end
            lrt_pkg::KIND_ERASE:
            begin
                if (hit_any)
                begin
                    mode       = lrt_pkg::MODE_REMOVE;
                    found_next = 1'b1;
                    cnt_next   = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                mode = lrt_pkg::MODE_HOLD;
            end
        endcase
        cell_ctl.key  = key_reg;
        cell_ctl.mode = seq_ctl.apply ? mode : lrt_pkg::MODE_HOLD;
    end

    genvar gi;
    generate
        for (gi = 0; gi < FRAMES; gi++)
        begin : g_cell
            logic            up_valid;
            logic [ID_W-1:0] up_id;
            logic            dn_valid;

            if (gi == FRAMES - 1)
            begin : g_top
                assign up_valid = 1'b0;
                assign up_id    = '0;
            end
            else
            begin : g_mid
                assign up_valid = valid_vec[gi+1];
                assign up_id    = id_vec[gi+1];
            end

            if (gi == 0)
            begin : g_bottom
                assign dn_valid = 1'b1;
            end
            else
            begin : g_upper
                assign dn_valid = valid_vec[gi-1];
            end

            lrt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl),
                .sel      (sel_vec[gi]),
                .up_valid (up_valid),
                .up_id    (up_id),
                .dn_valid (dn_valid),
                .valid    (valid_vec[gi]),
                .id       (id_vec[gi]),
                .hit      (hit_vec[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            kind_reg <= req.kind;
            key_reg  <= req.frame_id;
        end
        if (seq_ctl.apply)
        begin
            found_reg  <= found_next;
            victim_reg <= victim_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (seq_ctl.apply)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = found_reg;
    assign rsp.victim_id     = victim_reg;
    assign rsp.tracked_count = cnt_reg;

    a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(cnt_reg))
        else $error("tracked count differs from occupied cells");

    a_row_compact: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("occupied cells are not contiguous from the least recent end");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("frame held in more than one cell");

    a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        seq_ctl.apply |=> rsp.valid && rsp.tracked_count == $past(cnt_next))
        else $error("response word not posted after update");

endmodule

`default_nettype wire

@@ hdl/lrt_cell.sv @@
// One recency slot: holds a frame number, compares it and shifts with its neighbours.
`default_nettype none

module lrt_cell (
    input  wire                       clk,
    input  wire                       rst_n,
    input  lrt_pkg::cell_ctl_t        ctl,
    input  wire                       sel,
    input  wire                       up_valid,
    input  wire [lrt_pkg::ID_W-1:0]   up_id,
    input  wire                       dn_valid,
    output logic                      valid,
    output logic [lrt_pkg::ID_W-1:0]  id,
    output logic                      hit
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [lrt_pkg::ID_W-1:0] id_reg;
    logic [lrt_pkg::ID_W-1:0] id_next;
    logic                     hit_reg;
    logic                     hit_next;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        hit_next   = valid_reg && (id_reg == ctl.key);
        unique case (ctl.mode)
            lrt_pkg::MODE_APPEND:
            begin
                if (!valid_reg && dn_valid)
                begin
                    valid_next = 1'b1;
                    id_next    = ctl.key;
                end
            end
            lrt_pkg::MODE_MOVE:
            begin
                if (sel)
                begin
                    id_next = up_valid ? up_id : ctl.key;
                end
            end
            lrt_pkg::MODE_REMOVE:
            begin
                if (sel)
                begin
                    valid_next = up_valid;
                    id_next    = up_id;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

@@ hdl/lrt_seq.sv @@
// Operation sequencer: accept, compare across the row, then update and post the result.
`default_nettype none

module lrt_seq (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    input  wire               out_free,
    output lrt_pkg::seq_ctl_t ctl
);

    lrt_pkg::state_t state_reg;
    lrt_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lrt_pkg::ST_CMP;
                end
            end
            lrt_pkg::ST_CMP:
            begin
                state_next = lrt_pkg::ST_APPLY;
            end
            lrt_pkg::ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = lrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.ready = 1'b0;
        ctl.apply = 1'b0;
        unique case (state_reg)
            lrt_pkg::ST_IDLE:
            begin
                ctl.ready = 1'b1;
            end
            lrt_pkg::ST_APPLY:
            begin
                ctl.apply = out_free;
            end
            default:
            begin
                ctl.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
